// ===== rtl/core/dict_entry_field_parser_unit_assert.svh =====
// Assertion macros for the dictionary entry field parser.
`ifndef DICT_ENTRY_FIELD_PARSER_UNIT_ASSERT_SVH
`define DICT_ENTRY_FIELD_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Condition holds at every clock edge outside reset.
`define DEFP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dict entry parser check failed");
// Antecedent implies consequent in the same cycle.
`define DEFP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dict entry parser check failed");
`else
`define DEFP_ASSERT_ALWAYS(label, cond)
`define DEFP_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

// ===== rtl/core/def_pkg.sv =====
// Shared types, codes and the type letter decoder of the entry field parser.
`default_nettype none
package def_pkg;

  localparam int MAX_SEQ_TYPES = 8;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // Type codes
  localparam logic [3:0] CODE_M       = 4'd0;
  localparam logic [3:0] CODE_L       = 4'd1;
  localparam logic [3:0] CODE_G       = 4'd2;
  localparam logic [3:0] CODE_T       = 4'd3;
  localparam logic [3:0] CODE_X_LOW   = 4'd4;
  localparam logic [3:0] CODE_Y       = 4'd5;
  localparam logic [3:0] CODE_K       = 4'd6;
  localparam logic [3:0] CODE_W_LOW   = 4'd7;
  localparam logic [3:0] CODE_H       = 4'd8;
  localparam logic [3:0] CODE_R       = 4'd9;
  localparam logic [3:0] CODE_W_UP    = 4'd10;
  localparam logic [3:0] CODE_P_UP    = 4'd11;
  localparam logic [3:0] CODE_X_UP    = 4'd12;
  localparam logic [3:0] CODE_UNKNOWN = 4'd13;
  // First code of the length-prefixed block types
  localparam logic [3:0] CODE_BLOCK_FIRST = CODE_W_UP;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_REPEATED  = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_SEQ_END   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_SEQ_COUNT   = 1'b0;
  localparam logic CFG_SEQ_LETTERS = 1'b1;

  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_TEXT,
    PH_LEN,
    PH_BLOCK,
    PH_SKIP
  } phase_t;

  // One classified byte in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic [3:0] code;
  } q_entry_t;

  // Queue status toward the front and the checks
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      "m":     r = CODE_M;
      "l":     r = CODE_L;
      "g":     r = CODE_G;
      "t":     r = CODE_T;
      "x":     r = CODE_X_LOW;
      "y":     r = CODE_Y;
      "k":     r = CODE_K;
      "w":     r = CODE_W_LOW;
      "h":     r = CODE_H;
      "r":     r = CODE_R;
      "W":     r = CODE_W_UP;
      "P":     r = CODE_P_UP;
      "X":     r = CODE_X_UP;
      default: r = CODE_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/def_if.sv =====
// Channel interfaces for entry bytes and parsed field results.
`default_nettype none
interface def_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface def_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] payload_byte;
  logic [3:0] type_code;
  logic       field_end;
  logic       entry_done;
  logic [2:0] error_code;
  modport source (output valid, output has_byte, output payload_byte, output type_code,
                  output field_end, output entry_done, output error_code, input ready);
  modport sink   (input valid, input has_byte, input payload_byte, input type_code,
                  input field_end, input entry_done, input error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/def_front.sv =====
// Front end: accepts entry bytes and tags each with its decoded type letter.
`default_nettype none
module def_front
  import def_pkg::*;
(
  def_in_if.sink   in_ch,
  input  q_status_t q_stat,
  output logic      push,
  output q_entry_t  push_entry
);

  // Take a transaction whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Classify the byte as a tagged-mode type letter
  always_comb begin
    push_entry.data_byte = in_ch.data_byte;
    push_entry.is_last   = in_ch.is_last;
    push_entry.code      = letter_code(in_ch.data_byte);
  end

endmodule
`default_nettype wire

// ===== rtl/core/def_queue.sv =====
// Short queue of classified bytes between front and back end.
`default_nettype none
module def_queue
  import def_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_stat
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop       = pop && (count_r != '0);
  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.count = count_r;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/def_back.sv =====
// Back end: field parser state machine, configuration registers, result register.
`default_nettype none
module def_back
  import def_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  q_entry_t     head,
  input  q_status_t    q_stat,
  output logic         pop,
  def_out_if.source    out_ch
);

  // Configuration
  logic [3:0]  seq_count_r;
  logic [63:0] seq_letters_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [1:0]  len_seen_r, len_seen_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [3:0]  cur_type_r, cur_type_nxt;
  logic [13:0] seen_r, seen_nxt;
  logic [3:0]  seq_pos_r, seq_pos_nxt;
  logic [2:0]  err_r, err_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        has_byte_r, has_byte_nxt;
  logic [7:0]  payload_r, payload_nxt;
  logic [3:0]  type_code_r, type_code_nxt;
  logic        field_end_r, field_end_nxt;
  logic        entry_done_r, entry_done_nxt;
  logic [2:0]  error_code_r, error_code_nxt;

  logic        advance;
  logic        emit;
  logic [3:0]  seq_cnt;
  logic        seq_mode;
  logic [7:0]  seq_letter;
  logic [3:0]  code;
  logic [31:0] len_shift;
  logic [31:0] remain_dec;
  logic [7:0]  b;
  logic        last;

  assign advance = !out_valid_r || out_ch.ready;
  assign pop     = advance && !q_stat.empty;
  assign b       = head.data_byte;
  assign last    = head.is_last;

  assign seq_cnt    = (seq_count_r > 4'(MAX_SEQ_TYPES)) ? 4'(MAX_SEQ_TYPES) : seq_count_r;
  assign seq_mode   = (seq_cnt != '0);
  assign seq_letter = seq_letters_r[8*seq_pos_r[2:0] +: 8];
  assign code       = seq_mode ? letter_code(seq_letter) : head.code;
  assign len_shift  = {remain_r[23:0], b};
  assign remain_dec = remain_r - 32'd1;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_count_r   <= '0;
      seq_letters_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEQ_COUNT:   seq_count_r   <= cfg_wdata[3:0];
        CFG_SEQ_LETTERS: seq_letters_r <= cfg_wdata;
        default:         seq_count_r   <= seq_count_r;
      endcase
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      len_seen_r  <= '0;
      remain_r    <= '0;
      cur_type_r  <= '0;
      seen_r      <= '0;
      seq_pos_r   <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_seen_r  <= len_seen_nxt;
      remain_r    <= remain_nxt;
      cur_type_r  <= cur_type_nxt;
      seen_r      <= seen_nxt;
      seq_pos_r   <= seq_pos_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      has_byte_r   <= has_byte_nxt;
      payload_r    <= payload_nxt;
      type_code_r  <= type_code_nxt;
      field_end_r  <= field_end_nxt;
      entry_done_r <= entry_done_nxt;
      error_code_r <= error_code_nxt;
    end
  end

  // Next state and result for the byte at the queue head
  always_comb begin
    phase_nxt      = phase_r;
    len_seen_nxt   = len_seen_r;
    remain_nxt     = remain_r;
    cur_type_nxt   = cur_type_r;
    seen_nxt       = seen_r;
    seq_pos_nxt    = seq_pos_r;
    err_nxt        = err_r;
    emit           = 1'b0;
    has_byte_nxt   = 1'b0;
    payload_nxt    = '0;
    type_code_nxt  = CODE_UNKNOWN;
    field_end_nxt  = 1'b0;
    entry_done_nxt = last;
    error_code_nxt = ERR_NONE;

    case (phase_r)
      PH_TYPE: begin
        if (seq_mode && (seq_pos_r >= seq_cnt)) begin
          emit = 1'b1; phase_nxt = PH_SKIP;
          err_nxt = ERR_SEQ_END; error_code_nxt = ERR_SEQ_END;
        end else if (code == CODE_UNKNOWN) begin
          emit = 1'b1; phase_nxt = PH_SKIP;
          err_nxt = ERR_UNKNOWN; error_code_nxt = ERR_UNKNOWN;
        end else if (seen_r[code]) begin
          emit = 1'b1; phase_nxt = PH_SKIP; type_code_nxt = code;
          err_nxt = ERR_REPEATED; error_code_nxt = ERR_REPEATED;
        end else begin
          seen_nxt       = seen_r | (14'd1 << code);
          cur_type_nxt   = code;
          type_code_nxt  = code;
          if (seq_mode) begin
            // First byte of a sequence field is already content
            seq_pos_nxt = seq_pos_r + 4'd1;
            emit        = 1'b1;
            if (b == CHAR_NUL) begin
              phase_nxt     = PH_TYPE;
              field_end_nxt = 1'b1;
            end else begin
              phase_nxt     = PH_TEXT;
              has_byte_nxt  = 1'b1;
              payload_nxt   = b;
              field_end_nxt = last;
            end
          end else if (code >= CODE_BLOCK_FIRST) begin
            if (last) begin
              emit = 1'b1; phase_nxt = PH_SKIP;
              err_nxt = ERR_TRUNCATED; error_code_nxt = ERR_TRUNCATED;
            end else begin
              phase_nxt    = PH_LEN;
              len_seen_nxt = '0;
              remain_nxt   = '0;
            end
          end else begin
            phase_nxt     = PH_TEXT;
            emit          = last;
            field_end_nxt = 1'b1;
          end
        end
      end

      PH_TEXT: begin
        emit          = 1'b1;
        type_code_nxt = cur_type_r;
        if (b == CHAR_NUL) begin
          phase_nxt     = PH_TYPE;
          field_end_nxt = 1'b1;
        end else begin
          has_byte_nxt  = 1'b1;
          payload_nxt   = b;
          field_end_nxt = last;
        end
      end

      PH_LEN: begin
        remain_nxt    = len_shift;
        type_code_nxt = cur_type_r;
        if (len_seen_r != 2'd3) begin
          len_seen_nxt = len_seen_r + 2'd1;
          if (last) begin
            emit = 1'b1; phase_nxt = PH_SKIP;
            err_nxt = ERR_TRUNCATED; error_code_nxt = ERR_TRUNCATED;
          end
        end else begin
          len_seen_nxt = '0;
          if ((len_shift == '0) || last) begin
            // Empty or clipped block closes at once
            emit          = 1'b1;
            phase_nxt     = PH_TYPE;
            remain_nxt    = '0;
            field_end_nxt = 1'b1;
          end else begin
            phase_nxt = PH_BLOCK;
          end
        end
      end

      PH_BLOCK: begin
        emit          = 1'b1;
        remain_nxt    = remain_dec;
        has_byte_nxt  = 1'b1;
        payload_nxt   = b;
        type_code_nxt = cur_type_r;
        if ((remain_dec == '0) || last) begin
          phase_nxt     = PH_TYPE;
          remain_nxt    = '0;
          field_end_nxt = 1'b1;
        end
      end

      PH_SKIP: begin
        emit           = last;
        error_code_nxt = err_r;
      end

      default: begin
        phase_nxt = PH_TYPE;
      end
    endcase

    // Drop all entry state after the final byte
    if (last) begin
      phase_nxt    = PH_TYPE;
      len_seen_nxt = '0;
      remain_nxt   = '0;
      cur_type_nxt = '0;
      seen_nxt     = '0;
      seq_pos_nxt  = '0;
      err_nxt      = ERR_NONE;
    end

    // Keep state unless a byte is popped
    if (!pop) begin
      phase_nxt    = phase_r;
      len_seen_nxt = len_seen_r;
      remain_nxt   = remain_r;
      cur_type_nxt = cur_type_r;
      seen_nxt     = seen_r;
      seq_pos_nxt  = seq_pos_r;
      err_nxt      = err_r;
    end

    // Load a new result or release the taken one
    if (pop) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.has_byte     = has_byte_r;
  assign out_ch.payload_byte = payload_r;
  assign out_ch.type_code    = type_code_r;
  assign out_ch.field_end    = field_end_r;
  assign out_ch.entry_done   = entry_done_r;
  assign out_ch.error_code   = error_code_r;

endmodule
`default_nettype wire

// ===== rtl/core/dict_entry_field_parser_unit.sv =====
// Top level of the dictionary entry field parser.
`default_nettype none
`include "dict_entry_field_parser_unit_assert.svh"
// Splits the bytes of one dictionary entry into typed fields and returns at most one
// result per byte. The block sustains one byte per cycle: the front end tags each
// accepted byte with its decoded type letter and places it in a four-entry queue, and
// the back end pops one byte per cycle into the field state machine, whose single
// per-byte update sets the rate. A byte that gives a result is first written into the
// queue and then, once the back end pops it, loads the result register that drives
// the output. A stalled output fills the queue and then holds off new bytes.
// Configuration: index 0 is seq_count (0 selects tagged mode), index 1 holds up to
// eight sequence type letters, first in the lowest byte. Write them between entries.
module dict_entry_field_parser_unit
  import def_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  def_in_if.sink      in_ch,
  def_out_if.source   out_ch
);

  q_status_t q_stat;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  def_front u_front (
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  def_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  def_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // Queue count stays within its depth and matches its flags
  `DEFP_ASSERT_ALWAYS(a_q_bound, q_stat.count <= QCNT_W'(QDEPTH))
  `DEFP_ASSERT_IMPLY(a_q_full, q_stat.full, q_stat.count == QCNT_W'(QDEPTH) && !q_stat.empty)
  // An error result never carries a byte or closes a field
  `DEFP_ASSERT_IMPLY(a_err_nobyte, out_ch.valid && out_ch.error_code != ERR_NONE,
                     !out_ch.has_byte && !out_ch.field_end)
  // A payload byte always belongs to a known type
  `DEFP_ASSERT_IMPLY(a_byte_typed, out_ch.valid && out_ch.has_byte,
                     out_ch.type_code != CODE_UNKNOWN && out_ch.error_code == ERR_NONE)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the dictionary entry field parser: predicted field results checked per transaction.
`timescale 1ns / 100ps

module tb_top;
  import def_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 80;

  // One parsed field result as seen on the output channel
  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_byte;
    logic [3:0] type_code;
    logic       field_end;
    logic       entry_done;
    logic [2:0] error_code;
  } field_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;

  def_in_if  in_ch ();
  def_out_if out_ch ();

  dict_entry_field_parser_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Type letters, indexed by type code
  logic [7:0] letter_tab [13] = '{"m", "l", "g", "t", "x", "y", "k", "w", "h", "r",
                                  "W", "P", "X"};

  // Parser state mirror and register copies
  phase_t      ph;
  logic [1:0]  len_cnt;
  logic [31:0] remaining;
  logic [3:0]  cur_type;
  logic [13:0] seen;
  logic [3:0]  seq_pos;
  logic [2:0]  err_latched;
  logic [3:0]  seq_count_q;
  logic [63:0] seq_letters_q;

  field_res_t  expected_fields [$];
  logic [7:0]  entry_buf [$];

  int unsigned fail_cnt      = 0;
  int unsigned parsed_items  = 0;
  int unsigned result_cnt    = 0;
  int unsigned error_results = 0;
  int unsigned entry_cnt     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned long_hold     = 0;
  bit          src_idle_en   = 1'b1;
  bit          sink_idle_en  = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- field prediction

  function automatic logic [3:0] decode_letter(input logic [7:0] c);
    for (int i = 0; i < 13; i++)
      if (letter_tab[i] == c) return 4'(i);
    return CODE_UNKNOWN;
  endfunction

  function automatic field_res_t mk_res(input logic hb, input logic [7:0] pb,
                                        input logic [3:0] tc, input logic fe,
                                        input logic ed, input logic [2:0] ec);
    return {hb, pb, tc, fe, ed, ec};
  endfunction

  function automatic void clear_entry();
    ph          = PH_TYPE;
    len_cnt     = '0;
    remaining   = '0;
    cur_type    = '0;
    seen        = '0;
    seq_pos     = '0;
    err_latched = ERR_NONE;
  endfunction

  // Latch an error and skip the rest of the entry
  function automatic field_res_t raise_err(input logic [2:0] ec, input logic [3:0] tc,
                                           input logic last);
    err_latched = ec;
    ph          = PH_SKIP;
    return mk_res(1'b0, 8'h00, tc, 1'b0, last, ec);
  endfunction

  // One byte of zero-terminated text; the zero closes the field
  function automatic field_res_t text_res(input logic [7:0] b, input logic last);
    if (b == CHAR_NUL) begin
      ph = PH_TYPE;
      return mk_res(1'b0, 8'h00, cur_type, 1'b1, last, ERR_NONE);
    end
    ph = PH_TEXT;
    return mk_res(1'b1, b, cur_type, last, last, ERR_NONE);
  endfunction

  // Advance the parser mirror by one byte and queue the result it gives, if any
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [3:0] active;
    logic [7:0] letter;
    logic [3:0] code;
    field_res_t res;
    bit         has_res;
    has_res = 1'b1;
    res     = '0;
    case (ph)
      PH_TYPE: begin
        active = (seq_count_q > MAX_SEQ_TYPES) ? 4'(MAX_SEQ_TYPES) : seq_count_q;
        letter = (active != 0) ? seq_letters_q[8*seq_pos[2:0] +: 8] : b;
        code   = decode_letter(letter);
        if (active != 0 && seq_pos >= active) begin
          res = raise_err(ERR_SEQ_END, CODE_UNKNOWN, last);
        end else if (code == CODE_UNKNOWN) begin
          res = raise_err(ERR_UNKNOWN, CODE_UNKNOWN, last);
        end else if (seen[code]) begin
          res = raise_err(ERR_REPEATED, code, last);
        end else begin
          seen[code] = 1'b1;
          cur_type   = code;
          if (active != 0) begin
            // sequence mode: this byte is already field content
            seq_pos++;
            res = text_res(b, last);
          end else if (code >= CODE_BLOCK_FIRST) begin
            if (last) begin
              res = raise_err(ERR_TRUNCATED, code, last);
            end else begin
              ph        = PH_LEN;
              len_cnt   = '0;
              remaining = '0;
              has_res   = 1'b0;
            end
          end else begin
            ph      = PH_TEXT;
            has_res = last;
            res     = mk_res(1'b0, 8'h00, code, 1'b1, 1'b1, ERR_NONE);
          end
        end
      end
      PH_TEXT: begin
        res = text_res(b, last);
      end
      PH_LEN: begin
        remaining = {remaining[23:0], b};
        if (len_cnt < 3) begin
          len_cnt++;
          has_res = last;
          if (last) res = raise_err(ERR_TRUNCATED, cur_type, last);
        end else begin
          len_cnt = '0;
          if (remaining == 0 || last) begin
            ph        = PH_TYPE;
            remaining = '0;
            res       = mk_res(1'b0, 8'h00, cur_type, 1'b1, last, ERR_NONE);
          end else begin
            ph      = PH_BLOCK;
            has_res = 1'b0;
          end
        end
      end
      PH_BLOCK: begin
        remaining--;
        if (remaining == 0 || last) begin
          ph        = PH_TYPE;
          remaining = '0;
          res       = mk_res(1'b1, b, cur_type, 1'b1, last, ERR_NONE);
        end else begin
          res = mk_res(1'b1, b, cur_type, 1'b0, 1'b0, ERR_NONE);
        end
      end
      default: begin
        has_res = last;
        res     = mk_res(1'b0, 8'h00, CODE_UNKNOWN, 1'b0, 1'b1, err_latched);
      end
    endcase
    if (has_res) expected_fields.push_back(res);
    if (last) clear_entry();
  endtask

  // ---------------------------------------------------------------- result checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Compare each output transaction with the oldest expected field result
  always @(posedge clk) begin : result_chk
    field_res_t got;
    field_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.has_byte, out_ch.payload_byte, out_ch.type_code,
             out_ch.field_end, out_ch.entry_done, out_ch.error_code};
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        fail_cnt++;
      end else begin
        want = expected_fields.pop_front();
        check_field("has_byte", want.has_byte, got.has_byte);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("type_code", want.type_code, got.type_code);
        check_field("field_end", want.field_end, got.field_end);
        check_field("entry_done", want.entry_done, got.entry_done);
        check_field("error_code", want.error_code, got.error_code);
        result_cnt++;
        if (want.error_code != ERR_NONE) error_results++;
      end
    end
  end

  // Hold off the output in random bursts, or for one long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // End the run when no transaction happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one byte, wait for its transaction, then predict it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_last   <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    if (ph != PH_SKIP) parsed_items++;
    parse_byte(b, last);
  endtask

  task automatic send_entry();
    int unsigned n;
    n = entry_buf.size();
    for (int i = 0; i < n; i++) send_byte(entry_buf[i], i == n - 1);
    entry_cnt++;
  endtask

  // Drop valid, wait for every expected result, then let bytes without results drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEQ_COUNT) seq_count_q = data[3:0];
    else seq_letters_q = data;
  endtask

  // Eight distinct valid type letters
  function automatic logic [63:0] pick_seq_letters();
    logic [63:0]  v;
    logic [13:0]  used;
    int unsigned  c;
    v    = '0;
    used = '0;
    for (int i = 0; i < 8; i++) begin
      do c = $urandom_range(0, 12); while (used[c]);
      used[c]      = 1'b1;
      v[8*i +: 8]  = letter_tab[c];
    end
    return v;
  endfunction

  // Build a tagged entry: mostly well formed, sometimes with stray or repeated
  // letters, clipped fields or cut short
  task automatic build_tagged_entry();
    logic [13:0]  used;
    int unsigned  nf;
    int unsigned  body;
    int unsigned  cut;
    logic [31:0]  len;
    int unsigned  code;
    bit           clipped;
    entry_buf.delete();
    used    = '0;
    clipped = 1'b0;
    nf      = $urandom_range(1, 4);
    for (int f = 0; f < nf && !clipped; f++) begin
      if ($urandom_range(0, 15) == 0) begin
        entry_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        code = $urandom_range(0, 12);
        if (used[code] && $urandom_range(0, 7) != 0) begin
          do code = $urandom_range(0, 12); while (used[code]);
        end
        used[code] = 1'b1;
        entry_buf.push_back(letter_tab[code]);
        if (code >= CODE_BLOCK_FIRST) begin
          len = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5));
          for (int s = 24; s >= 0; s -= 8) entry_buf.push_back(len[s +: 8]);
          body = (len > 6) ? $urandom_range(0, 6) : len;
          for (int i = 0; i < body; i++) entry_buf.push_back(8'($urandom_range(0, 255)));
          if (body < len) clipped = 1'b1;
        end else begin
          body = $urandom_range(0, 5);
          for (int i = 0; i < body; i++) entry_buf.push_back(8'($urandom_range(1, 255)));
          if (f != nf - 1 || $urandom_range(0, 3) != 0) entry_buf.push_back(CHAR_NUL);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, entry_buf.size());
      while (entry_buf.size() > cut) void'(entry_buf.pop_back());
    end
  endtask

  // Build a sequence mode entry, at times with one field too many
  task automatic build_seq_entry();
    int unsigned active;
    int unsigned nf;
    int unsigned body;
    entry_buf.delete();
    active = (seq_count_q > MAX_SEQ_TYPES) ? MAX_SEQ_TYPES : seq_count_q;
    nf     = $urandom_range(1, active + 1);
    for (int f = 0; f < nf; f++) begin
      body = $urandom_range(0, 4);
      for (int i = 0; i < body; i++) entry_buf.push_back(8'($urandom_range(1, 255)));
      if (body == 0 || f != nf - 1 || $urandom_range(0, 3) != 0)
        entry_buf.push_back(CHAR_NUL);
    end
  endtask

  task automatic build_noise_entry();
    entry_buf.delete();
    repeat ($urandom_range(1, 6)) entry_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned stop_at;
    stop_at = parsed_items + target;
    while (parsed_items < stop_at) begin
      if ($urandom_range(0, 9) < 2) build_noise_entry();
      else if (seq_count_q == 0) build_tagged_entry();
      else build_seq_entry();
      send_entry();
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset configuration is tagged mode
  task automatic test_tagged_directed();
    // text with terminator, then a block that ends on the last byte
    entry_buf = '{"m", 8'h7f, 8'h00, "W", 8'h00, 8'h00, 8'h00, 8'h01, 8'hff};
    send_entry();
    // zero-length block, then a lowercase letter as the last byte
    entry_buf = '{"P", 8'h00, 8'h00, 8'h00, 8'h00, "l"};
    send_entry();
    // unknown letter, rest skipped
    entry_buf = '{"Z", 8'h01};
    send_entry();
    // repeated type on the last byte
    entry_buf = '{"x", 8'h00, "x"};
    send_entry();
    // length cut short by the last byte
    entry_buf = '{"X", 8'h80, 8'h00};
    send_entry();
    // text clipped by the last byte
    entry_buf = '{"k", 8'h41};
    send_entry();
  endtask

  task automatic test_seq_directed();
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 28'($urandom), 4'd2});
    write_reg(CFG_SEQ_LETTERS, {48'hfedc_ba98_7654, "X", "r"});
    // empty first field, one-byte second field, then the sequence runs out
    entry_buf = '{8'h00, 8'h31, 8'h00, 8'h55, 8'h66};
    send_entry();
    // field start that is also the last byte
    entry_buf = '{8'h41};
    send_entry();
  endtask

  task automatic test_tagged_random();
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 28'($urandom), 4'd0});
    write_reg(CFG_SEQ_LETTERS, '1);
    run_random(200);
  endtask

  task automatic test_seq_random();
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 28'($urandom), 4'd8});
    write_reg(CFG_SEQ_LETTERS, pick_seq_letters());
    run_random(100);
    // counts above the limit act as eight; random letters are mostly unknown
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 28'($urandom), 4'd15});
    write_reg(CFG_SEQ_LETTERS, {32'($urandom), 32'($urandom)});
    run_random(30);
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 28'($urandom), 4'd1});
    write_reg(CFG_SEQ_LETTERS, {32'($urandom), 24'($urandom), "h"});
    run_random(40);
  endtask

  // Hold the output for a long stretch while a long text field keeps coming
  task automatic test_backpressure();
    write_reg(CFG_SEQ_COUNT, 64'd0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    long_hold    = LONG_HOLD;
    entry_buf.delete();
    entry_buf.push_back("t");
    repeat (40) entry_buf.push_back(8'($urandom_range(1, 255)));
    entry_buf.push_back(CHAR_NUL);
    send_entry();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Final stretch runs at full rate on both sides
  task automatic test_full_rate();
    write_reg(CFG_SEQ_LETTERS, 64'd0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random(100);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SEQ_COUNT;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_last   = 1'b0;
    out_ch.ready    = 1'b0;
    seq_count_q     = '0;
    seq_letters_q   = '0;
    clear_entry();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tagged_directed();
    test_seq_directed();
    test_tagged_random();
    test_seq_random();
    test_backpressure();
    test_full_rate();
    wait_idle();

    $display("Covered %0d entries, %0d parsed bytes, %0d field results (%0d with errors)",
             entry_cnt, parsed_items, result_cnt, error_results);
    $display("Tagged and sequence modes, counts 0/1/2/8/15, idle bursts and a long hold");
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
